// ----- rtl/bpfr_pkg.sv -----
// Shared types and constants of the buffer-pool frame table.
// No dependencies.
`default_nettype none
package bpfr_pkg;
	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 16;
	localparam int PIN_BITS  = 8;
	localparam int FIDX_BITS = 4;
	localparam int CNT_BITS  = 32;

	localparam logic [1:0] REQ_PIN   = 2'd0;
	localparam logic [1:0] REQ_UNPIN = 2'd1;
	localparam logic [1:0] REQ_DIRTY = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_NORES  = 2'd2;

	localparam logic CFG_FRAMES = 1'b0;
	localparam logic CFG_POLICY = 1'b1;

	typedef logic [FIDX_BITS-1:0] fidx_t;
	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [PIN_BITS-1:0]  pin_t;

	// Per-frame contents.
	typedef struct packed {
		page_t tag;
		logic  valid;
		pin_t  pins;
		logic  dirty;
	} frame_t;

	// Command from the controller to every cell of the frame table.
	typedef struct packed {
		logic  upd;
		fidx_t frame;
		frame_t data;
	} fcmd_t;

	// Command to the order chain: remove a frame and append it at the tail.
	typedef struct packed {
		logic  move;
		fidx_t frame;
	} ocmd_t;
endpackage
`default_nettype wire

// ----- rtl/bpfr_order_cell.sv -----
// One position of the replacement order chain.
// Depends on bpfr_pkg.
`default_nettype none
module bpfr_order_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  bpfr_pkg::fidx_t     reset_frame,
	input  wire                 is_tail,
	input  bpfr_pkg::ocmd_t     cmd,
	input  wire                 found_left,   // moved frame sits left of here
	input  bpfr_pkg::fidx_t     right_frame,  // neighbour to the right
	output bpfr_pkg::fidx_t     frame,
	output logic                found_here
);
	import bpfr_pkg::*;
	fidx_t frame_q;

	assign frame = frame_q;
	assign found_here = found_left | (frame_q == cmd.frame);

	// Positions from the moved frame onwards shift left by one; the tail takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= reset_frame;
		end else if (cmd.move && found_here) begin
			frame_q <= is_tail ? cmd.frame : right_frame;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/bpfr_frame_cell.sv -----
// One frame of the table: tag, valid, pin count and dirty bit, with its tag compare.
// Depends on bpfr_pkg.
`default_nettype none
module bpfr_frame_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  bpfr_pkg::fidx_t     my_index,
	input  bpfr_pkg::fcmd_t     cmd,
	input  bpfr_pkg::page_t     page,
	output bpfr_pkg::frame_t    data,
	output logic                match
);
	import bpfr_pkg::*;
	frame_t data_q;

	assign data = data_q;
	assign match = data_q.valid && (data_q.tag == page);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (cmd.upd && cmd.frame == my_index) begin
			data_q <= cmd.data;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/buffer_pool_frame_replacement.sv -----
// Top level of the buffer-pool frame table: control sequencer, frame cells, order chain.
// Depends on bpfr_pkg, bpfr_frame_cell and bpfr_order_cell.
// Steps from request to result: match, victim search, update, result (LOOKUP, SEARCH,
// UPDATE, RESULT). The sequencer takes each request only in IDLE and holds one request
// at a time, so a result that waits in RESULT for the output register holds off the next.
// A result waits in an output register. Reset: asynchronous; frames empty, order i at
// position i, counters zero, 16 frames, FIFO.
`default_nettype none
module buffer_pool_frame_replacement (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // req_type[1:0], page_num[17:2], zero fill
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [95:0] m_tdata,   // status, hit, frame_index, evict_valid, evict_page,
	                               // load_valid, read_count, write_count, zero fill
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [4:0]  cfg_data
);
	import bpfr_pkg::*;

	typedef enum logic [2:0] {IDLE, LOOKUP, SEARCH, UPDATE, RESULT} state_t;
	state_t state_q;

	logic [1:0] req_q;
	page_t      page_q;
	logic [4:0] frames_q;
	logic       policy_q;
	logic [CNT_BITS-1:0] loads_q, wbs_q;

	frame_t     fdata [FRAMES];
	logic [FRAMES-1:0] fmatch;
	fidx_t      ofr [FRAMES];
	logic [FRAMES:0] ofound;
	fcmd_t      fcmd;
	ocmd_t      ocmd;

	logic       hit_q, victim_ok_q;
	fidx_t      hidx_q, vidx_q;

	// Result fields up to load_valid, held until the output register is free.
	logic [24:0] res_d, res_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == IDLE);

	logic [4:0] nused;
	always_comb begin
		if (frames_q == 5'd0) nused = 5'd1;
		else if (frames_q > 5'(FRAMES)) nused = 5'(FRAMES);
		else nused = frames_q;
	end

	genvar g;
	generate
		for (g = 0; g < FRAMES; g++) begin : g_cell
			bpfr_frame_cell u_frame (
				.clk(clk), .arst_n(arst_n), .my_index(fidx_t'(g)), .cmd(fcmd),
				.page(page_q), .data(fdata[g]), .match(fmatch[g])
			);
			bpfr_order_cell u_order (
				.clk(clk), .arst_n(arst_n), .reset_frame(fidx_t'(g)),
				.is_tail(g == FRAMES - 1), .cmd(ocmd), .found_left(ofound[g]),
				.right_frame(ofr[(g + 1) % FRAMES]), .frame(ofr[g]),
				.found_here(ofound[g + 1])
			);
		end
	endgenerate
	assign ofound[0] = 1'b0;

	// Lowest matching used frame.
	logic  m_any;
	fidx_t m_idx;
	always_comb begin
		m_any = 1'b0;
		m_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (fmatch[i] && (5'(i) < nused)) begin
				m_any = 1'b1;
				m_idx = fidx_t'(i);
			end
		end
	end

	// First unpinned used frame in replacement order.
	logic  v_any;
	fidx_t v_idx;
	always_comb begin
		v_any = 1'b0;
		v_idx = '0;
		for (int p = FRAMES - 1; p >= 0; p--) begin
			if ({1'b0, ofr[p]} < nused && fdata[ofr[p]].pins == '0) begin
				v_any = 1'b1;
				v_idx = ofr[p];
			end
		end
	end

	frame_t hf, vf;
	assign hf = fdata[hidx_q];
	assign vf = fdata[vidx_q];

	always_comb begin
		fcmd = '0;
		ocmd = '0;
		if (state_q == UPDATE) begin
			if (hit_q) begin
				fcmd.upd = (req_q == REQ_PIN) || (req_q == REQ_UNPIN) || (req_q == REQ_DIRTY);
				fcmd.frame = hidx_q;
				fcmd.data = hf;
				unique case (req_q)
					REQ_PIN:   if (hf.pins != '1) fcmd.data.pins = hf.pins + 1'b1;
					REQ_UNPIN: if (hf.pins != '0) fcmd.data.pins = hf.pins - 1'b1;
					REQ_DIRTY: fcmd.data.dirty = 1'b1;
					default:   fcmd.upd = 1'b0;
				endcase
				ocmd.move = (req_q == REQ_PIN) && policy_q;
				ocmd.frame = hidx_q;
			end else if (req_q == REQ_PIN && victim_ok_q) begin
				fcmd.upd = 1'b1;
				fcmd.frame = vidx_q;
				fcmd.data.tag = page_q;
				fcmd.data.valid = 1'b1;
				fcmd.data.pins = pin_t'(1);
				fcmd.data.dirty = 1'b0;
				ocmd.move = 1'b1;
				ocmd.frame = vidx_q;
			end
		end
	end

	always_comb begin
		res_d = '0;
		if (hit_q && ((req_q == REQ_PIN) || (req_q == REQ_UNPIN) || (req_q == REQ_DIRTY))) begin
			res_d[1:0] = ST_OK;
			res_d[2] = 1'b1;
			res_d[6:3] = hidx_q;
		end else if (req_q != REQ_PIN) begin
			res_d[1:0] = ST_NORES;
		end else if (!victim_ok_q) begin
			res_d[1:0] = ST_NOFREE;
		end else begin
			res_d[6:3] = vidx_q;
			res_d[24] = 1'b1;
			if (vf.valid && vf.dirty) begin
				res_d[7] = 1'b1;
				res_d[23:8] = vf.tag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			m_tvalid <= 1'b0;
			frames_q <= 5'd16;
			policy_q <= 1'b0;
			loads_q <= '0;
			wbs_q <= '0;
			hit_q <= 1'b0;
			victim_ok_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_FRAMES) frames_q <= cfg_data;
				else policy_q <= cfg_data[0];
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				IDLE: if (s_tvalid) begin
					req_q <= s_tdata[1:0];
					page_q <= s_tdata[17:2];
					state_q <= LOOKUP;
				end
				LOOKUP: begin
					hit_q <= m_any;
					hidx_q <= m_idx;
					state_q <= SEARCH;
				end
				SEARCH: begin
					victim_ok_q <= v_any;
					vidx_q <= v_idx;
					state_q <= UPDATE;
				end
				UPDATE: begin
					res_q <= res_d;
					if (res_d[24]) loads_q <= loads_q + 1'b1;
					if (res_d[7]) wbs_q <= wbs_q + 1'b1;
					state_q <= RESULT;
				end
				RESULT: if (!m_tvalid) begin
					m_tdata <= {7'd0, wbs_q, loads_q, res_q};
					m_tvalid <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/bpfr_checker.sv -----
// Port-level checks of the buffer-pool frame table, bound to the top level.
// Depends on buffer_pool_frame_replacement only through its ports.
`default_nettype none
module bpfr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [95:0] m_tdata
);
	// A request taken blocks further requests for the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("request taken while busy");
	// A result never shows a hit together with a load.
	a_hitload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[24])) else $error("hit with load");
	// Write-back implies load.
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[24]) else $error("evict without load");
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
endmodule
bind buffer_pool_frame_replacement bpfr_checker u_bpfr_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the buffer-pool frame table: directed cases, then random phases.
// Depends on bpfr_pkg and buffer_pool_frame_replacement; carries its own frame-table predictor.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bpfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [1:0] REQ_BAD = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		fidx_t       frame_index;
		logic        evict_valid;
		page_t       evict_page;
		logic        load_valid;
		logic [31:0] read_count;
		logic [31:0] write_count;
	} pool_result_t;

	typedef struct {
		bit         is_cfg;
		logic [1:0] a;
		page_t      b;
		bit         has_exp;
		logic [1:0] exp_status;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;

	buffer_pool_frame_replacement u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	page_t       pm_tag[FRAMES];
	bit          pm_valid[FRAMES];
	int unsigned pm_pins[FRAMES];
	bit          pm_dirty[FRAMES];
	int unsigned pm_order[FRAMES];
	logic [31:0] pm_loads, pm_writebacks;
	logic [4:0]  pm_frames;
	bit          pm_lru;

	pool_result_t expected_results[$];
	int errors = 0;
	int accepted_reqs = 0;
	int checked_results = 0;
	int snd_pct = 0;
	int rcv_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	function automatic int unsigned active_frames();
		if (pm_frames == 0) return 1;
		if (pm_frames > FRAMES) return FRAMES;
		return pm_frames;
	endfunction

	function automatic void order_to_tail(int unsigned fr);
		int p;
		p = 0;
		while (p < FRAMES && pm_order[p] != fr) p++;
		for (int q = p; q + 1 < FRAMES; q++) pm_order[q] = pm_order[q + 1];
		pm_order[FRAMES - 1] = fr;
	endfunction

	function automatic pool_result_t pool_step(logic [1:0] rq, page_t pg);
		pool_result_t r;
		int f, victim;
		int unsigned n;
		r = '0;
		n = active_frames();
		f = -1;
		for (int i = 0; i < n; i++)
			if (f < 0 && pm_valid[i] && pm_tag[i] == pg) f = i;
		if (rq == REQ_PIN) begin
			if (f >= 0) begin
				r.hit = 1'b1;
				r.frame_index = fidx_t'(f);
				if (pm_pins[f] < 255) pm_pins[f]++;
				if (pm_lru) order_to_tail(f);
			end else begin
				victim = -1;
				for (int p = 0; p < FRAMES; p++)
					if (victim < 0 && pm_order[p] < n && pm_pins[pm_order[p]] == 0)
						victim = pm_order[p];
				if (victim < 0) begin
					r.status = ST_NOFREE;
				end else begin
					r.frame_index = fidx_t'(victim);
					if (pm_valid[victim] && pm_dirty[victim]) begin
						r.evict_valid = 1'b1;
						r.evict_page = pm_tag[victim];
						pm_writebacks++;
					end
					r.load_valid = 1'b1;
					pm_loads++;
					pm_tag[victim] = pg;
					pm_valid[victim] = 1'b1;
					pm_dirty[victim] = 1'b0;
					pm_pins[victim] = 1;
					order_to_tail(victim);
				end
			end
		end else if ((rq == REQ_UNPIN || rq == REQ_DIRTY) && f >= 0) begin
			r.hit = 1'b1;
			r.frame_index = fidx_t'(f);
			if (rq == REQ_UNPIN) begin
				if (pm_pins[f] > 0) pm_pins[f]--;
			end else begin
				pm_dirty[f] = 1'b1;
			end
		end else begin
			r.status = ST_NORES;
		end
		r.read_count = pm_loads;
		r.write_count = pm_writebacks;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch at t=%0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// Result side: stalls at negedge, checks at posedge.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_pct);
		end
	end

	always @(posedge clk) begin
		pool_result_t got, want;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got.status      = m_tdata[1:0];
			got.hit         = m_tdata[2];
			got.frame_index = m_tdata[6:3];
			got.evict_valid = m_tdata[7];
			got.evict_page  = m_tdata[23:8];
			got.load_valid  = m_tdata[24];
			got.read_count  = m_tdata[56:25];
			got.write_count = m_tdata[88:57];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], 0);
			end else begin
				want = expected_results.pop_front();
				checked_results++;
				if (got.status != want.status) report_mismatch("status", got.status, want.status);
				if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
				if (got.frame_index != want.frame_index)
					report_mismatch("frame_index", got.frame_index, want.frame_index);
				if (got.evict_valid != want.evict_valid)
					report_mismatch("evict_valid", got.evict_valid, want.evict_valid);
				if (got.evict_page != want.evict_page)
					report_mismatch("evict_page", got.evict_page, want.evict_page);
				if (got.load_valid != want.load_valid)
					report_mismatch("load_valid", got.load_valid, want.load_valid);
				if (got.read_count != want.read_count)
					report_mismatch("read_count", got.read_count, want.read_count);
				if (got.write_count != want.write_count)
					report_mismatch("write_count", got.write_count, want.write_count);
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_req(logic [1:0] rq, page_t pg, output pool_result_t r);
		int gap;
		@(negedge clk);
		if ($urandom_range(99) < snd_pct) begin
			s_tvalid = 1'b0;
			gap = $urandom_range(6, 1);
			repeat (gap - 1) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {6'd0, pg, rq};
		do @(posedge clk); while (!s_tready);
		r = pool_step(rq, pg);
		expected_results.push_back(r);
		accepted_reqs++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		drain_results();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_FRAMES) pm_frames = val;
		else pm_lru = val[0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_phase(int items, logic [4:0] frames, bit lru, int sp, int rp);
		pool_result_t r;
		page_t base, pg;
		logic [1:0] rq;
		int pool, roll;
		write_reg(CFG_FRAMES, frames);
		write_reg(CFG_POLICY, {4'd0, lru});
		snd_pct = sp;
		rcv_pct = rp;
		base = page_t'($urandom());
		pool = 2 * ((frames == 0) ? 1 : (frames > FRAMES ? FRAMES : frames)) + 2;
		for (int k = 0; k < items; k++) begin
			roll = $urandom_range(99);
			rq = (roll < 48) ? REQ_PIN : (roll < 82) ? REQ_UNPIN : (roll < 96) ? REQ_DIRTY : REQ_BAD;
			pg = base ^ page_t'($urandom_range(pool - 1));
			if ($urandom_range(99) < 6) pg = page_t'($urandom());
			send_req(rq, pg, r);
		end
	endtask

	step_t steps[$] = '{
		'{0, REQ_PIN,   16'h0000, 1, ST_OK},
		'{0, REQ_PIN,   16'hFFFF, 1, ST_OK},
		'{0, REQ_PIN,   16'h0000, 1, ST_OK},
		'{0, REQ_DIRTY, 16'hFFFF, 1, ST_OK},
		'{0, REQ_UNPIN, 16'hFFFF, 1, ST_OK},
		'{0, REQ_UNPIN, 16'hFFFF, 1, ST_OK},
		'{0, REQ_UNPIN, 16'h1234, 1, ST_NORES},
		'{0, REQ_DIRTY, 16'h1234, 1, ST_NORES},
		'{0, REQ_BAD,   16'h0000, 1, ST_NORES},
		'{1, CFG_FRAMES, 16'd0,   0, ST_OK},
		'{0, REQ_PIN,   16'h0005, 1, ST_NOFREE},
		'{0, REQ_UNPIN, 16'h0000, 1, ST_OK},
		'{0, REQ_UNPIN, 16'h0000, 1, ST_OK},
		'{0, REQ_PIN,   16'h0005, 1, ST_OK},
		'{0, REQ_DIRTY, 16'h0005, 1, ST_OK},
		'{0, REQ_UNPIN, 16'h0005, 1, ST_OK},
		'{0, REQ_PIN,   16'h0009, 1, ST_OK},
		'{0, REQ_PIN,   16'hFFFF, 1, ST_NOFREE},
		'{1, CFG_FRAMES, 16'd31,  0, ST_OK},
		'{1, CFG_POLICY, 16'd1,   0, ST_OK},
		'{0, REQ_PIN,   16'hFFFF, 1, ST_OK},
		'{0, REQ_PIN,   16'h0009, 1, ST_OK},
		'{0, REQ_PIN,   16'h5555, 1, ST_OK},
		'{0, REQ_PIN,   16'hAAAA, 1, ST_OK}
	};

	initial begin
		pool_result_t r;
		for (int i = 0; i < FRAMES; i++) begin
			pm_tag[i] = '0;
			pm_valid[i] = 1'b0;
			pm_pins[i] = 0;
			pm_dirty[i] = 1'b0;
			pm_order[i] = i;
		end
		pm_loads = '0;
		pm_writebacks = '0;
		pm_frames = 5'd16;
		pm_lru = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (steps[i]) begin
			if (steps[i].is_cfg) begin
				write_reg(steps[i].a[0], steps[i].b[4:0]);
			end else begin
				send_req(steps[i].a, steps[i].b, r);
				if (steps[i].has_exp && r.status != steps[i].exp_status)
					report_mismatch("directed status", r.status, steps[i].exp_status);
			end
		end

		// Saturate one pin count, with LRU and a small pool.
		write_reg(CFG_FRAMES, 5'd3);
		for (int k = 0; k < 258; k++) send_req(REQ_PIN, 16'h0F0F, r);

		// Long result stall while requests keep coming, so the input backs up.
		drain_results();
		hold_cycles = 300;
		for (int k = 0; k < 12; k++) send_req(REQ_UNPIN, 16'h0F0F, r);

		random_phase(30, 5'd4, 1'b0, 0, 0);
		random_phase(30, 5'd16, 1'b1, 63, 0);
		random_phase(20, 5'd2, 1'b1, 0, 63);
		random_phase(25, 5'd8, 1'b0, 37, 37);
		random_phase(15, 5'd1, 1'b1, 37, 37);
		random_phase(15, 5'd0, 1'b0, 0, 63);
		random_phase(25, 5'd20, 1'b1, 0, 0);

		drain_results();
		$display("covered %0d requests, %0d results checked, frame counts 0..31, FIFO and LRU",
			accepted_reqs, checked_results);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
